// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the local segment finder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CLSF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be seen outside reset.
`define CLSF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `CLSF_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== hdl/clsf_pkg.sv =====
// Types, codes and constants of the local segment finder.
// No dependencies; imported by every module of the block except clsf_fifo.
`default_nettype none

package clsf_pkg;

  localparam int PosBitsDef   = 16;
  localparam int ScoreBitsDef = 32;
  // widest per-operation score step: 16 bit length times 8 bit weight plus open
  localparam int DELTA_BITS   = 25;
  localparam int CFG_IDX_BITS = 3;
  localparam int MID_DEPTH    = 2;
  localparam int RES_DEPTH    = 4;
  localparam int MAX_RES      = 3;

  typedef enum logic [1:0] {
    OP_MATCH    = 2'd0,
    OP_MISMATCH = 2'd1,
    OP_INSERT   = 2'd2,
    OP_DELETE   = 2'd3
  } op_kind_e;

  typedef enum logic [2:0] {
    PREV_MATCH    = 3'd0,
    PREV_MISMATCH = 3'd1,
    PREV_INSERT   = 3'd2,
    PREV_DELETE   = 3'd3,
    PREV_NONE     = 3'd4
  } prev_kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MATCH      = 3'd0,
    CFG_MISMATCH   = 3'd1,
    CFG_GAP_OPEN   = 3'd2,
    CFG_GAP_EXTEND = 3'd3,
    CFG_MIN_SCORE  = 3'd4,
    CFG_MIN_IDENT  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OUT_SEGMENT = 1'b0,
    OUT_SUMMARY = 1'b1
  } out_kind_e;

  typedef struct packed {
    op_kind_e    op_kind;
    logic [15:0] op_length;
    logic        op_last;
  } op_t;

  typedef struct packed {
    out_kind_e          out_kind;
    logic [15:0]        seg_begin_read;
    logic [15:0]        seg_end_read;
    logic [15:0]        seg_begin_ref;
    logic [15:0]        seg_end_ref;
    logic [15:0]        seg_first_op;
    logic [15:0]        seg_end_op;
    logic signed [31:0] seg_score;
    logic [15:0]        seg_identity;
    logic signed [31:0] best_score;
    logic               out_last;
  } res_t;

  // classified operation handed from front to back
  typedef struct packed {
    op_kind_e                     kind;
    logic [15:0]                  len;
    logic                         last;
    logic signed [DELTA_BITS-1:0] delta;
  } cmd_t;

  typedef struct packed {
    logic [6:0]         match;
    logic signed [7:0]  mismatch;
    logic signed [7:0]  gap_open;
    logic signed [7:0]  gap_extend;
    logic signed [31:0] min_score;
    logic [15:0]        min_ident;
  } cfg_t;

  // up to three result beats written by the back end in one cycle
  typedef struct packed {
    logic [1:0]              n;
    res_t [MAX_RES-1:0]      row;
  } res_wr_t;

endpackage

`default_nettype wire

// ===== hdl/cigar_local_segment_finder_core.sv =====
// Top level of the local segment finder: config registers, front, queue, back.
// Depends on clsf_pkg, clsf_front, clsf_fifo, clsf_back, clsf_res_queue, assert_macros.svh.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------
//  op in   | push / full            | op_i (op_t)
//  result  | empty / pop            | res_o (res_t)
//  config  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One operation per cycle sustained while the result queue has room; the score update in the back end sets it.
// A result is registered in the operation queue and then in the result queue before it is on the ports.
// The back end holds when the result queue has fewer than three free slots.
// Reset is asynchronous: registers to defaults, state cleared, no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module cigar_local_segment_finder_core import clsf_pkg::*; #(
  parameter int POS_BITS   = PosBitsDef,
  parameter int SCORE_BITS = ScoreBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  op_t                     op_i,
  output logic                    empty,
  input  logic                    pop,
  output res_t                    res_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [31:0]             cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  cmd_t    cmd_in, cmd_q;
  logic    mid_empty, cmd_pop, res_room;
  res_wr_t res_wr;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MATCH:      cfg_d.match      = cfg_data_i[6:0];
        CFG_MISMATCH:   cfg_d.mismatch   = signed'(cfg_data_i[7:0]);
        CFG_GAP_OPEN:   cfg_d.gap_open   = signed'(cfg_data_i[7:0]);
        CFG_GAP_EXTEND: cfg_d.gap_extend = signed'(cfg_data_i[7:0]);
        CFG_MIN_SCORE:  cfg_d.min_score  = signed'(cfg_data_i);
        CFG_MIN_IDENT:  cfg_d.min_ident  = cfg_data_i[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match      <= 7'd1;
      cfg_q.mismatch   <= -8'sd4;
      cfg_q.gap_open   <= -8'sd6;
      cfg_q.gap_extend <= -8'sd1;
      cfg_q.min_score  <= 32'sd20;
      cfg_q.min_ident  <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: classify and form the score step
  clsf_front u_front (
    .cfg_i (cfg_q),
    .op_i  (op_i),
    .cmd_o (cmd_in)
  );

  // decoupling queue between front and back
  clsf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_q),
    .empty_o (mid_empty)
  );

  // back: running state and result beats
  clsf_back #(
    .POS_BITS   (POS_BITS),
    .SCORE_BITS (SCORE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd_q),
    .cmd_valid_i (!mid_empty),
    .res_room_i  (res_room),
    .cmd_pop_o   (cmd_pop),
    .res_wr_o    (res_wr)
  );

  clsf_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .room_o  (res_room),
    .pop_i   (pop),
    .head_o  (res_o),
    .empty_o (empty)
  );

  // checks
  `CLSF_ASSERT(a_summary_lands, clk_i, rst_ni, (cmd_pop && cmd_q.last) |=> !empty, "summary beat missing after last operation")
  `CLSF_ASSERT_NEVER(a_pop_mid_empty, clk_i, rst_ni, cmd_pop && mid_empty, "back end took an operation from an empty queue")
  `CLSF_ASSERT(a_kind_last, clk_i, rst_ni, !empty |-> (res_o.out_last == (res_o.out_kind == OUT_SUMMARY)), "out_last does not match out_kind")
  `CLSF_ASSERT(a_seg_best_zero, clk_i, rst_ni, (!empty && (res_o.out_kind == OUT_SEGMENT)) |-> (res_o.best_score == 32'sd0), "segment beat carries a best score")

endmodule

`default_nettype wire

// ===== hdl/clsf_fifo.sv =====
// Small generic FIFO used between the front and back ends.
// No package dependency; DEPTH must be a power of two.
`default_nettype none

module clsf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // pointer and count update
  always_comb begin
    wptr_d = do_push ? wptr_q + AW'(1) : wptr_q;
    rptr_d = do_pop  ? rptr_q + AW'(1) : rptr_q;
    cnt_d  = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/clsf_front.sv =====
// Front end: classifies one edit operation and forms its score step.
// Depends on clsf_pkg (op_t, cmd_t, cfg_t).
`default_nettype none

module clsf_front import clsf_pkg::*; (
  input  cfg_t cfg_i,
  input  op_t  op_i,
  output cmd_t cmd_o
);

  logic signed [16:0] mul_a;
  logic signed [8:0]  mul_b;
  logic signed [25:0] prod;
  logic signed [25:0] gap_sum;

  // one 17x9 signed multiply: match weight or gap extend weight
  assign mul_a   = signed'({1'b0, op_i.op_length});
  assign mul_b   = (op_i.op_kind == OP_MATCH) ? signed'({2'b00, cfg_i.match})
                                              : signed'({cfg_i.gap_extend[7], cfg_i.gap_extend});
  assign prod    = mul_a * mul_b;
  assign gap_sum = prod + 26'(cfg_i.gap_open);

  always_comb begin
    cmd_o.kind = op_i.op_kind;
    cmd_o.len  = op_i.op_length;
    cmd_o.last = op_i.op_last;
    case (op_i.op_kind)
      OP_MATCH:    cmd_o.delta = DELTA_BITS'(prod);
      OP_MISMATCH: cmd_o.delta = DELTA_BITS'(cfg_i.mismatch);
      default:     cmd_o.delta = DELTA_BITS'(gap_sum);
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/clsf_back.sv =====
// Back end: running score, positions, held best segment and result beats.
// Depends on clsf_pkg (cmd_t, cfg_t, res_t, res_wr_t, kind codes).
`default_nettype none

module clsf_back import clsf_pkg::*; #(
  parameter int POS_BITS   = PosBitsDef,
  parameter int SCORE_BITS = ScoreBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  cmd_t    cmd_i,
  input  logic    cmd_valid_i,
  input  logic    res_room_i,
  output logic    cmd_pop_o,
  output res_wr_t res_wr_o
);

  localparam int SW  = ((SCORE_BITS > DELTA_BITS) ? SCORE_BITS : DELTA_BITS) + 1;
  localparam int PSW = ((POS_BITS > 16) ? POS_BITS : 16) + 1;
  localparam logic signed [SCORE_BITS-1:0] ScoreMax = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] ScoreMin = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam logic [POS_BITS-1:0]          PosMax   = '1;

  typedef logic signed [SCORE_BITS-1:0] score_t;
  typedef logic [POS_BITS-1:0]          pos_t;

  function automatic pos_t pos_add(input pos_t a, input logic [15:0] b);
    logic [PSW-1:0] s;
    s = PSW'(a) + PSW'(b);
    return (s > PSW'(PosMax)) ? PosMax : s[POS_BITS-1:0];
  endfunction

  function automatic logic [15:0] cnt_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic meets(input score_t s, input logic [15:0] id);
    return (s >= cfg_i.min_score) && (id >= cfg_i.min_ident);
  endfunction

  function automatic res_t seg_row(input score_t s, input logic [15:0] id,
                                   input pos_t br, input pos_t er,
                                   input pos_t bf, input pos_t ef,
                                   input logic [15:0] fo, input logic [15:0] eo);
    res_t r;
    r.out_kind       = OUT_SEGMENT;
    r.seg_begin_read = 16'(br);
    r.seg_end_read   = 16'(er);
    r.seg_begin_ref  = 16'(bf);
    r.seg_end_ref    = 16'(ef);
    r.seg_first_op   = fo;
    r.seg_end_op     = eo;
    r.seg_score      = 32'(s);
    r.seg_identity   = id;
    r.best_score     = '0;
    r.out_last       = 1'b0;
    return r;
  endfunction

  // running state
  score_t      run_score_q, run_score_d;
  logic [15:0] run_ident_q, run_ident_d;
  pos_t        read_pos_q, read_pos_d, ref_pos_q, ref_pos_d;
  logic [15:0] op_cnt_q, op_cnt_d;
  prev_kind_e  prev_kind_q, prev_kind_d;
  // held best prefix of the current segment
  score_t      held_score_q, held_score_d;
  logic [15:0] held_ident_q, held_ident_d;
  pos_t        beg_read_q, beg_read_d, end_read_q, end_read_d;
  pos_t        beg_ref_q, beg_ref_d, end_ref_q, end_ref_d;
  logic [15:0] first_op_q, first_op_d, end_op_q, end_op_d;
  score_t      top_q, top_d;

  logic              fire;
  logic signed [SW-1:0] sum_w;
  score_t            score_new;
  logic [15:0]       read_inc, ref_inc, id_inc;
  pos_t              read_new, ref_new;
  logic [15:0]       id_new, op_new;
  logic              adjacent, greater, restart, emit1, emit2;
  score_t            top1, top2;
  res_t              row_a, row_b, row_s;

  assign fire      = cmd_valid_i && res_room_i;
  assign cmd_pop_o = fire;

  // score step with saturation
  assign sum_w     = SW'(run_score_q) + SW'(cmd_i.delta);
  assign score_new = (sum_w > SW'(ScoreMax)) ? ScoreMax :
                     (sum_w < SW'(ScoreMin)) ? ScoreMin : SCORE_BITS'(sum_w);

  // position and identity increments per kind
  always_comb begin
    read_inc = '0;
    ref_inc  = '0;
    id_inc   = '0;
    case (cmd_i.kind)
      OP_MATCH: begin
        read_inc = cmd_i.len;
        ref_inc  = cmd_i.len;
        id_inc   = cmd_i.len;
      end
      OP_MISMATCH: begin
        read_inc = 16'd1;
        ref_inc  = 16'd1;
      end
      OP_INSERT: ref_inc  = cmd_i.len;
      default:   read_inc = cmd_i.len;
    endcase
  end

  assign read_new = pos_add(read_pos_q, read_inc);
  assign ref_new  = pos_add(ref_pos_q, ref_inc);
  assign id_new   = cnt_add(run_ident_q, id_inc);
  assign op_new   = cnt_add(op_cnt_q, 16'd1);

  // insertion right after deletion or the reverse
  assign adjacent = ((cmd_i.kind == OP_INSERT) && (prev_kind_q == PREV_DELETE)) ||
                    ((cmd_i.kind == OP_DELETE) && (prev_kind_q == PREV_INSERT));
  assign greater  = score_new > held_score_q;
  assign restart  = adjacent || (!greater && (score_new < 0));
  assign emit1    = !adjacent && !greater && (score_new < 0) &&
                    meets(held_score_q, held_ident_q);

  // segment bookkeeping after this operation
  always_comb begin
    run_score_d  = score_new;
    run_ident_d  = id_new;
    held_score_d = held_score_q;
    held_ident_d = held_ident_q;
    beg_read_d   = beg_read_q;
    beg_ref_d    = beg_ref_q;
    end_read_d   = end_read_q;
    end_ref_d    = end_ref_q;
    first_op_d   = first_op_q;
    end_op_d     = end_op_q;
    if (restart) begin
      run_score_d  = '0;
      run_ident_d  = '0;
      held_score_d = '0;
      held_ident_d = '0;
      beg_read_d   = read_new;
      beg_ref_d    = ref_new;
      first_op_d   = op_new;
    end else if (greater) begin
      held_score_d = score_new;
      held_ident_d = id_new;
      end_read_d   = read_new;
      end_ref_d    = ref_new;
      end_op_d     = op_new;
    end
  end

  // best reported score, updated by each emitted segment in order
  assign emit2 = cmd_i.last && meets(held_score_d, held_ident_d);
  assign top1  = (emit1 && (held_score_q > top_q)) ? held_score_q : top_q;
  assign top2  = (emit2 && (held_score_d > top1)) ? held_score_d : top1;

  // result beats
  assign row_a = seg_row(held_score_q, held_ident_q, beg_read_q, end_read_q,
                         beg_ref_q, end_ref_q, first_op_q, end_op_q);
  assign row_b = seg_row(held_score_d, held_ident_d, beg_read_d, end_read_d,
                         beg_ref_d, end_ref_d, first_op_d, end_op_d);

  always_comb begin
    row_s            = '0;
    row_s.out_kind   = OUT_SUMMARY;
    row_s.best_score = 32'(top2);
    row_s.out_last   = 1'b1;
  end

  always_comb begin
    res_wr_o.n      = fire ? (2'(emit1) + 2'(emit2) + 2'(cmd_i.last)) : 2'd0;
    res_wr_o.row[2] = row_s;
    res_wr_o.row[1] = (emit1 && emit2) ? row_b : row_s;
    res_wr_o.row[0] = emit1 ? row_a : (emit2 ? row_b : row_s);
  end

  assign prev_kind_d = prev_kind_e'({1'b0, cmd_i.kind});
  assign top_d       = top1;

  // commit; the last operation returns everything to reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_score_q  <= '0;
      run_ident_q  <= '0;
      read_pos_q   <= '0;
      ref_pos_q    <= '0;
      op_cnt_q     <= '0;
      prev_kind_q  <= PREV_NONE;
      held_score_q <= '0;
      held_ident_q <= '0;
      beg_read_q   <= '0;
      beg_ref_q    <= '0;
      end_read_q   <= '0;
      end_ref_q    <= '0;
      first_op_q   <= '0;
      end_op_q     <= '0;
      top_q        <= ScoreMin;
    end else if (fire) begin
      if (cmd_i.last) begin
        run_score_q  <= '0;
        run_ident_q  <= '0;
        read_pos_q   <= '0;
        ref_pos_q    <= '0;
        op_cnt_q     <= '0;
        prev_kind_q  <= PREV_NONE;
        held_score_q <= '0;
        held_ident_q <= '0;
        beg_read_q   <= '0;
        beg_ref_q    <= '0;
        end_read_q   <= '0;
        end_ref_q    <= '0;
        first_op_q   <= '0;
        end_op_q     <= '0;
        top_q        <= ScoreMin;
      end else begin
        run_score_q  <= run_score_d;
        run_ident_q  <= run_ident_d;
        read_pos_q   <= read_new;
        ref_pos_q    <= ref_new;
        op_cnt_q     <= op_new;
        prev_kind_q  <= prev_kind_d;
        held_score_q <= held_score_d;
        held_ident_q <= held_ident_d;
        beg_read_q   <= beg_read_d;
        beg_ref_q    <= beg_ref_d;
        end_read_q   <= end_read_d;
        end_ref_q    <= end_ref_d;
        first_op_q   <= first_op_d;
        end_op_q     <= end_op_d;
        top_q        <= top_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/clsf_res_queue.sv =====
// Result queue: takes up to three beats per cycle, hands out one.
// Depends on clsf_pkg (res_t, res_wr_t, RES_DEPTH, MAX_RES).
`default_nettype none

module clsf_res_queue import clsf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  res_wr_t wr_i,
  output logic    room_o,
  input  logic    pop_i,
  output res_t    head_o,
  output logic    empty_o
);

  localparam int AW = $clog2(RES_DEPTH);

  res_t          mem_q [RES_DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_pop;

  assign empty_o = (cnt_q == '0);
  assign room_o  = (cnt_q <= (AW+1)'(RES_DEPTH - MAX_RES));
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];
  assign cnt_d   = cnt_q + (AW+1)'(wr_i.n) - (AW+1)'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + AW'(wr_i.n);
      rptr_q <= rptr_q + AW'(do_pop);
      cnt_q  <= cnt_d;
    end
  end

  // beats land in consecutive slots from the write pointer
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (k < int'(wr_i.n)) begin
        mem_q[wptr_q + AW'(k)] <= wr_i.row[k];
      end
    end
  end

endmodule

`default_nettype wire
